// ===== rtl/grid_local_extremum_classifier_macros.svh =====
// Assertion macros for the grid local extremum classifier.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef GRID_LOCAL_EXTREMUM_CLASSIFIER_MACROS_SVH
`define GRID_LOCAL_EXTREMUM_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glec assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define GLEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glec assertion failed one cycle later");

`endif

// ===== rtl/glec_pkg.sv =====
// Shared constants, types and codes of the grid local extremum classifier.
// Used by the channel interfaces and every module of the block.
package glec_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
    localparam int DIM_BITS     = 11;
    localparam int COORD_BITS   = 10;
    localparam int CFG_BITS     = 11;
    localparam int CLASS_BITS   = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [CLASS_BITS-1:0] {
        CLASS_NONE   = 2'd0,
        CLASS_PEAK   = 2'd1,
        CLASS_VALLEY = 2'd2
    } cell_class_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // Per-transaction control decoded from the scan position.
    typedef struct packed {
        logic                 shift;
        logic                 res_valid;
        logic                 left_ok;
        logic                 right_ok;
        logic                 up_ok;
        logic                 down_ok;
        logic                 frame_last;
        logic [ADDR_BITS-1:0] col;
        logic [ADDR_BITS-1:0] x;
        logic [DIM_BITS-1:0]  y;
    } pos_t;

endpackage

// ===== rtl/glec_sample_if.sv =====
// Input channel of the classifier: one height sample or drain marker per transaction.
// Depends on glec_pkg for the sample type.
interface glec_sample_if import glec_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    kind;
    sample_t height_sample;

    modport source (output valid, output kind, output height_sample, input ready);
    modport sink   (input valid, input kind, input height_sample, output ready);
endinterface

// ===== rtl/glec_cell_if.sv =====
// Output channel of the classifier: one classified cell per transaction.
// Depends on glec_pkg for the field widths.
interface glec_cell_if import glec_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cell_column;
    logic [COORD_BITS-1:0] cell_row;
    logic [CLASS_BITS-1:0] cell_class;
    logic                  frame_last;

    modport source (output valid, output cell_column, output cell_row,
                    output cell_class, output frame_last, input ready);
    modport sink   (input valid, input cell_column, input cell_row,
                    input cell_class, input frame_last, output ready);
endinterface

// ===== rtl/glec_scan.sv =====
// Frame geometry registers, raster position counters and per-transaction decode.
// Depends on glec_pkg.
module glec_scan import glec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                accept,
    input  logic                kind,
    output logic                ignore,
    output pos_t                pos,
    output logic [DIM_BITS-1:0] w_eff,
    output logic [DIM_BITS-1:0] h_eff
);

    logic [DIM_BITS-1:0]  width_reg;
    logic [DIM_BITS-1:0]  height_reg;
    logic [ADDR_BITS-1:0] col_reg;
    logic [DIM_BITS-1:0]  row_reg;
    logic [DIM_BITS-1:0]  col_plus;
    logic                 terminate;
    logic                 col_zero;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_BITS'(1);
        else if (width_reg > DIM_BITS'(MAX_WIDTH))
            w_eff = DIM_BITS'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DIM_BITS'(1);
        else if (height_reg > DIM_BITS'(HEIGHT_LIMIT))
            h_eff = DIM_BITS'(HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    // The row counter passes the last row by one while the bottom edge drains;
    // the transaction after that row closes the frame.
    assign terminate = row_reg > h_eff;
    assign col_zero  = col_reg == '0;
    assign ignore    = kind && (row_reg < h_eff);
    assign col_plus  = DIM_BITS'(col_reg) + DIM_BITS'(1);

    always_comb
    begin
        pos       = '0;
        pos.shift = !terminate;
        pos.col   = col_reg;
        if (col_zero)
        begin
            // Last cell of the row two back: its right-hand column is off the grid.
            pos.res_valid  = row_reg >= DIM_BITS'(2);
            pos.x          = ADDR_BITS'(w_eff - DIM_BITS'(1));
            pos.y          = row_reg - DIM_BITS'(2);
            pos.left_ok    = w_eff >= DIM_BITS'(2);
            pos.right_ok   = 1'b0;
            pos.up_ok      = row_reg >= DIM_BITS'(3);
            pos.down_ok    = row_reg <= h_eff;
            pos.frame_last = terminate;
        end
        else
        begin
            pos.res_valid  = (row_reg >= DIM_BITS'(1)) && !terminate;
            pos.x          = col_reg - ADDR_BITS'(1);
            pos.y          = row_reg - DIM_BITS'(1);
            pos.left_ok    = col_reg >= ADDR_BITS'(2);
            pos.right_ok   = 1'b1;
            pos.up_ok      = row_reg >= DIM_BITS'(2);
            pos.down_ok    = row_reg < h_eff;
            pos.frame_last = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(MAX_WIDTH);
            height_reg <= DIM_BITS'(HEIGHT_LIMIT);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept && !ignore)
        begin
            if (terminate)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (col_plus >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= row_reg + DIM_BITS'(1);
            end
            else
            begin
                col_reg <= col_plus[ADDR_BITS-1:0];
            end
        end
    end

endmodule

// ===== rtl/glec_line_store.sv =====
// Two line stores holding the previous two grid rows, read with registered data.
// Depends on glec_pkg. A write and a read of the same column on one edge are forwarded.
module glec_line_store import glec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  sample_t              wr_fresh,
    output sample_t              above1,
    output sample_t              above2
);

    sample_t mem_a [MAX_WIDTH];
    sample_t mem_b [MAX_WIDTH];
    sample_t a_rd_reg;
    sample_t b_rd_reg;
    sample_t fwd_a_reg;
    sample_t fwd_b_reg;
    logic    hit_reg;

    // Row store A holds the row just above; its old entry moves down into store B.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_fresh;
            mem_b[wr_addr] <= above1;
        end
        if (rd_en)
        begin
            a_rd_reg  <= mem_a[rd_addr];
            b_rd_reg  <= mem_b[rd_addr];
            fwd_a_reg <= wr_fresh;
            fwd_b_reg <= above1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (rd_en)
            hit_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign above1 = hit_reg ? fwd_a_reg : a_rd_reg;
    assign above2 = hit_reg ? fwd_b_reg : b_rd_reg;

endmodule

// ===== rtl/glec_window.sv =====
// Window columns around the current cell and the eight-neighbor compare.
// Depends on glec_pkg; the right-hand column comes from the line stores and the sample register.
module glec_window import glec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  pos_t        pos,
    input  sample_t     above2,
    input  sample_t     above1,
    input  sample_t     fresh,
    output cell_class_t cls
);

    // Only two stored columns are needed: the window's left column is always
    // the previous middle column at the time a cell is classified.
    sample_t win_l_reg [3];
    sample_t win_c_reg [3];
    sample_t nb        [8];
    logic    nb_ok     [8];
    sample_t centre;
    logic    peak;
    logic    valley;

    assign centre = win_c_reg[1];

    always_comb
    begin
        nb[0] = win_l_reg[0];  nb_ok[0] = pos.left_ok && pos.up_ok;
        nb[1] = win_l_reg[1];  nb_ok[1] = pos.left_ok;
        nb[2] = win_l_reg[2];  nb_ok[2] = pos.left_ok && pos.down_ok;
        nb[3] = win_c_reg[0];  nb_ok[3] = pos.up_ok;
        nb[4] = win_c_reg[2];  nb_ok[4] = pos.down_ok;
        nb[5] = above2;        nb_ok[5] = pos.right_ok && pos.up_ok;
        nb[6] = above1;        nb_ok[6] = pos.right_ok;
        nb[7] = fresh;         nb_ok[7] = pos.right_ok && pos.down_ok;

        peak   = 1'b1;
        valley = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (nb_ok[i] && !(nb[i] < centre))
                peak = 1'b0;
            if (nb_ok[i] && !(nb[i] > centre))
                valley = 1'b0;
        end

        if (peak)
            cls = CLASS_PEAK;
        else if (valley)
            cls = CLASS_VALLEY;
        else
            cls = CLASS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_l_reg[i] <= '0;
                win_c_reg[i] <= '0;
            end
        end
        else if (advance && pos.shift)
        begin
            for (int i = 0; i < 3; i++)
                win_l_reg[i] <= win_c_reg[i];
            win_c_reg[0] <= above2;
            win_c_reg[1] <= above1;
            win_c_reg[2] <= fresh;
        end
    end

endmodule

// ===== rtl/grid_local_extremum_classifier.sv =====
// Grid local extremum classifier. Takes one height sample per clock in raster order
// unless the output stalls, and gives one result per cell: peak, valley or neither
// against its 3x3 neighborhood. Sustained rate is one transaction per clock unless
// the output stalls; a transaction passes an input stage (line store read) and a
// compare stage into the result register. A cell completes frame_width+1
// transactions after its own sample, so after the last sample send frame_width+1
// drain transactions (kind = 1); the last one carries frame_last and restarts the
// frame. Drain transactions sent while grid rows are still due are dropped. Width
// and height are set through the write port; write them only while idle, as the
// block does not check it. A write restarts the frame, a value of 0 acts as 1 and
// values above 1024 as 1024. The line stores need no clearing pass after reset.
`include "grid_local_extremum_classifier_macros.svh"

module grid_local_extremum_classifier import glec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    glec_sample_if.sink         samples,
    glec_cell_if.source         cells,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    pos_t                  pos;
    pos_t                  s1_pos_reg;
    sample_t               s1_sample_reg;
    logic                  s1_valid_reg;
    logic                  s1_advance;
    logic                  in_accept;
    logic                  ignore;
    logic                  load;
    logic                  out_free;
    logic [DIM_BITS-1:0]   w_eff;
    logic [DIM_BITS-1:0]   h_eff;
    sample_t               above1;
    sample_t               above2;
    cell_class_t           cls;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_col_reg;
    logic [COORD_BITS-1:0] out_row_reg;
    logic [CLASS_BITS-1:0] out_class_reg;
    logic                  out_last_reg;

    assign out_free      = !out_valid_reg || cells.ready;
    assign s1_advance    = s1_valid_reg && (!s1_pos_reg.res_valid || out_free);
    assign samples.ready = !s1_valid_reg || s1_advance;
    assign in_accept     = samples.valid && samples.ready;
    assign load          = in_accept && !ignore;

    glec_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (in_accept),
        .kind      (samples.kind),
        .ignore    (ignore),
        .pos       (pos),
        .w_eff     (w_eff),
        .h_eff     (h_eff)
    );

    glec_line_store u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (load),
        .rd_addr  (pos.col),
        .wr_en    (s1_advance && s1_pos_reg.shift),
        .wr_addr  (s1_pos_reg.col),
        .wr_fresh (s1_sample_reg),
        .above1   (above1),
        .above2   (above2)
    );

    glec_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .pos     (s1_pos_reg),
        .above2  (above2),
        .above1  (above1),
        .fresh   (s1_sample_reg),
        .cls     (cls)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_pos_reg <= '0;
        else if (load)
            s1_pos_reg <= pos;
    end

    // The sample value of a drain transaction lands only in off-grid positions.
    always_ff @(posedge clk)
    begin
        if (load)
            s1_sample_reg <= samples.height_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_pos_reg.res_valid)
            out_valid_reg <= 1'b1;
        else if (cells.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_pos_reg.res_valid)
        begin
            out_col_reg   <= COORD_BITS'(s1_pos_reg.x);
            out_row_reg   <= COORD_BITS'(s1_pos_reg.y);
            out_class_reg <= cls;
            out_last_reg  <= s1_pos_reg.frame_last;
        end
    end

    assign cells.valid       = out_valid_reg;
    assign cells.cell_column = out_col_reg;
    assign cells.cell_row    = out_row_reg;
    assign cells.cell_class  = out_class_reg;
    assign cells.frame_last  = out_last_reg;

    `GLEC_ASSERT_NOW(a_last_at_corner, cells.valid && cells.frame_last, (cells.cell_column == COORD_BITS'(w_eff - DIM_BITS'(1))) && (cells.cell_row == COORD_BITS'(h_eff - DIM_BITS'(1))))
    `GLEC_ASSERT_NEXT(a_result_held, s1_valid_reg && s1_pos_reg.res_valid && !out_free, s1_valid_reg && s1_pos_reg.res_valid)
    `GLEC_ASSERT_NEXT(a_result_issued, s1_advance && s1_pos_reg.res_valid, cells.valid)

endmodule
